// ===== hdl/bsmn_pkg.sv =====
package bsmn_pkg;

  localparam int unsigned ROOT_STEPS  = 33;
  localparam int unsigned FRAC_STEPS  = 32;
  localparam int unsigned SCALE_STEPS = 47;
  localparam int unsigned CNT_W       = 6;

  localparam logic [30:0] TARGET_RESET   = 31'd65536;
  localparam logic [30:0] IDENTITY_SCALE = 31'd65536;
  localparam logic [30:0] MIN_RADIUS     = 31'd7;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] sphere_radius;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic [30:0]        uniform_scale;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQUARE,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_TEST,
    ST_FRAC,
    ST_MOVE,
    ST_PREP,
    ST_SCALE,
    ST_OFFSET,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_MOVE,
    MUL_OFF
  } mul_mode_t;

  typedef struct packed {
    logic      load;
    logic      delta;
    logic      take_new;
    logic      mul_go;
    mul_mode_t mul_mode;
    logic [1:0] mul_sel;
    logic [1:0] wr_sel;
    logic      sq_wr;
    logic      acc_first;
    logic      move_wr;
    logic      off_wr;
    logic      root_init;
    logic      root_step;
    logic      merge;
    logic      div_step;
    logic      scale_init;
    logic      scale_latch;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic item_pos;
    logic have;
    logic last;
    logic contain_agg;
    logic contain_new;
    logic d_zero;
    logic out_busy;
  } status_t;

endpackage

// ===== hdl/bsmn_ctrl.sv =====
module bsmn_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  bsmn_pkg::status_t st,
  output bsmn_pkg::cmd_t   cmd
);
  import bsmn_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  state_t           finish_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign finish_state = st.last ? ST_PREP : ST_IDLE;

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 1'b1;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cnt_next = '0;
        if (!st.item_pos || !st.have) state_next = finish_state;
        else state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (cnt == CNT_W'(3)) begin
          state_next = ST_ROOT_INIT;
          cnt_next   = '0;
        end
      end
      ST_ROOT_INIT: begin
        cnt_next   = '0;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          state_next = ST_TEST;
          cnt_next   = '0;
        end
      end
      ST_TEST: begin
        cnt_next = '0;
        if (st.contain_agg || st.contain_new || st.d_zero) state_next = finish_state;
        else state_next = ST_FRAC;
      end
      ST_FRAC: begin
        if (cnt == CNT_W'(FRAC_STEPS - 1)) begin
          state_next = ST_MOVE;
          cnt_next   = '0;
        end
      end
      ST_MOVE: begin
        if (cnt == CNT_W'(3)) begin
          state_next = finish_state;
          cnt_next   = '0;
        end
      end
      ST_PREP: begin
        cnt_next   = '0;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        if (cnt == CNT_W'(SCALE_STEPS)) begin
          state_next = ST_OFFSET;
          cnt_next   = '0;
        end
      end
      ST_OFFSET: begin
        if (cnt == CNT_W'(3)) begin
          state_next = ST_EMIT;
          cnt_next   = '0;
        end
      end
      ST_EMIT: begin
        cnt_next = '0;
        if (!st.out_busy) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE:  cmd.load = in_valid;
      ST_CHECK: begin
        cmd.delta    = 1'b1;
        cmd.take_new = st.item_pos && !st.have;
      end
      ST_SQUARE: begin
        cmd.mul_go    = (cnt < CNT_W'(3));
        cmd.mul_mode  = MUL_SQ;
        cmd.mul_sel   = cnt[1:0];
        cmd.sq_wr     = (cnt != '0);
        cmd.acc_first = (cnt == CNT_W'(1));
        cmd.wr_sel    = cnt[1:0] - 2'd1;
      end
      ST_ROOT_INIT: cmd.root_init = 1'b1;
      ST_ROOT:      cmd.root_step = 1'b1;
      ST_TEST: begin
        cmd.take_new = !st.contain_agg && st.contain_new;
        cmd.merge    = !st.contain_agg && !st.contain_new;
      end
      ST_FRAC: cmd.div_step = 1'b1;
      ST_MOVE: begin
        cmd.mul_go   = (cnt < CNT_W'(3));
        cmd.mul_mode = MUL_MOVE;
        cmd.mul_sel  = cnt[1:0];
        cmd.move_wr  = (cnt != '0);
        cmd.wr_sel   = cnt[1:0] - 2'd1;
      end
      ST_PREP: cmd.scale_init = 1'b1;
      ST_SCALE: begin
        cmd.div_step    = (cnt != CNT_W'(SCALE_STEPS));
        cmd.scale_latch = (cnt == CNT_W'(SCALE_STEPS));
      end
      ST_OFFSET: begin
        cmd.mul_go   = (cnt < CNT_W'(3));
        cmd.mul_mode = MUL_OFF;
        cmd.mul_sel  = cnt[1:0];
        cmd.off_wr   = (cnt != '0);
        cmd.wr_sel   = cnt[1:0] - 2'd1;
      end
      ST_EMIT: cmd.emit = !st.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/bsmn_datapath.sv =====
module bsmn_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [30:0]         cfg_data,
  input  bsmn_pkg::in_word_t  in_data,
  input  bsmn_pkg::cmd_t      cmd,
  output bsmn_pkg::status_t   st,
  output logic                out_valid,
  input  logic                out_stall,
  output bsmn_pkg::out_word_t out_data
);
  import bsmn_pkg::*;

  in_word_t    item;
  logic [30:0] target;
  logic        have;
  logic [31:0] agg_c [3];
  logic [30:0] arad;
  logic [32:0] delta [3];
  logic [65:0] sum;
  logic [63:0] prod;
  logic [65:0] rad;
  logic [33:0] srem;
  logic [32:0] root;
  logic [33:0] den;
  logic [33:0] drem;
  logic [46:0] q;
  logic        ksat;
  logic [30:0] scale;
  logic [31:0] offs [3];

  logic [31:0] item_c [3];
  logic [30:0] item_r;
  logic [31:0] mag_d, mag_c, frac, mul_a, mul_b;
  logic [35:0] rt, rtrial;
  logic [34:0] dt;
  logic [33:0] far_agg, far_new, nr, kval;
  logic [32:0] moved;
  logic [31:0] mv_m;
  logic [47:0] off_m;
  logic [31:0] off_c, off_v;

  assign item_c[0] = item.center_x;
  assign item_c[1] = item.center_y;
  assign item_c[2] = item.center_z;
  assign item_r    = item.sphere_radius[30:0];

  always_comb begin
    logic [32:0] dsel;
    dsel  = delta[cmd.mul_sel];
    mag_d = dsel[32] ? 32'(-dsel) : dsel[31:0];
    mag_c = agg_c[cmd.mul_sel][31] ? -agg_c[cmd.mul_sel] : agg_c[cmd.mul_sel];
    frac  = ksat ? '1 : q[31:0];
    case (cmd.mul_mode)
      MUL_SQ: begin
        mul_a = mag_d;
        mul_b = mag_d;
      end
      MUL_MOVE: begin
        mul_a = mag_d;
        mul_b = frac;
      end
      MUL_OFF: begin
        mul_a = mag_c;
        mul_b = {1'b0, scale};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sums of the distance against both radii
  assign far_agg = 34'(root) + 34'(item_r);
  assign far_new = 34'(root) + 34'(arad);
  assign nr      = 34'((35'(root) + 35'(arad) + 35'(item_r)) >> 1);
  assign kval    = (nr > 34'(arad)) ? nr - 34'(arad) : '0;

  assign rt     = {srem, rad[65:64]};
  assign rtrial = {1'b0, root, 2'b01};
  assign dt     = {drem, q[46]};

  assign mv_m  = prod[63:32];
  assign moved = delta[cmd.wr_sel][32] ? {agg_c[cmd.wr_sel][31], agg_c[cmd.wr_sel]} - 33'(mv_m)
                                       : {agg_c[cmd.wr_sel][31], agg_c[cmd.wr_sel]} + 33'(mv_m);

  // saturate the offset, sign opposite to the center
  assign off_m = prod[63:16];
  assign off_c = agg_c[cmd.wr_sel];
  always_comb begin
    if (!off_c[31] && (off_c != '0)) begin
      off_v = (off_m > 48'h8000_0000) ? 32'h8000_0000 : -off_m[31:0];
    end else begin
      off_v = (off_m > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : off_m[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target    <= TARGET_RESET;
      have      <= 1'b0;
      arad      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) agg_c[i] <= '0;
    end else begin
      if (cfg_write) target <= cfg_data;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.take_new) begin
        for (int i = 0; i < 3; i++) agg_c[i] <= item_c[i];
        arad <= item_r;
        have <= 1'b1;
      end
      if (cmd.merge) arad <= (nr > 34'h7FFF_FFFF) ? 31'h7FFF_FFFF : nr[30:0];
      if (cmd.move_wr) agg_c[cmd.wr_sel] <= moved[31:0];
      if (cmd.emit) begin
        have      <= 1'b0;
        arad      <= '0;
        for (int i = 0; i < 3; i++) agg_c[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
    if (cmd.delta) begin
      for (int i = 0; i < 3; i++) begin
        delta[i] <= {item_c[i][31], item_c[i]} - {agg_c[i][31], agg_c[i]};
      end
    end
    if (cmd.mul_go) prod <= mul_a * mul_b;
    if (cmd.sq_wr) sum <= cmd.acc_first ? 66'(prod) : sum + 66'(prod);
    if (cmd.root_init) begin
      rad  <= sum;
      srem <= '0;
      root <= '0;
    end
    if (cmd.root_step) begin
      rad <= {rad[63:0], 2'b00};
      if (rt >= rtrial) begin
        srem <= 34'(rt - rtrial);
        root <= {root[31:0], 1'b1};
      end else begin
        srem <= rt[33:0];
        root <= {root[31:0], 1'b0};
      end
    end
    if (cmd.merge) begin
      drem <= kval;
      ksat <= (kval >= 34'(root));
      den  <= 34'(root);
      q    <= '0;
    end
    if (cmd.scale_init) begin
      drem <= '0;
      q    <= {target, 16'b0};
      den  <= 34'((arad < MIN_RADIUS) ? MIN_RADIUS : arad);
    end
    if (cmd.div_step) begin
      if (dt >= {1'b0, den}) begin
        drem <= 34'(dt - {1'b0, den});
        q    <= {q[45:0], 1'b1};
      end else begin
        drem <= dt[33:0];
        q    <= {q[45:0], 1'b0};
      end
    end
    if (cmd.scale_latch) scale <= (q > 47'h7FFF_FFFF) ? 31'h7FFF_FFFF : q[30:0];
    if (cmd.off_wr) offs[cmd.wr_sel] <= off_v;
    if (cmd.emit) begin
      if (have) begin
        out_data <= {1'b1, scale, offs[0], offs[1], offs[2]};
      end else begin
        out_data <= {1'b0, IDENTITY_SCALE, 32'd0, 32'd0, 32'd0};
      end
    end
  end

  assign st.item_pos    = !item.sphere_radius[31] && (item_r != '0);
  assign st.have        = have;
  assign st.last        = item.last;
  assign st.contain_agg = (34'(arad) >= far_agg);
  assign st.contain_new = (34'(item_r) >= far_new);
  assign st.d_zero      = (root == '0);
  assign st.out_busy    = out_valid && out_stall;

endmodule

// ===== hdl/bounding_sphere_merge_normalize.sv =====
// Merges a list of spheres into one enclosing sphere and, on the word marked
// last, returns the scale and offset that bring it to target_radius. One
// word is worked on at a time, with the center distance from a shared 32x32
// multiplier and a two-bit-per-cycle square root, and the center shift and
// the scale from one shared restoring divider. A skipped word or the first
// kept sphere needs only the check; a merged sphere adds the square, the root
// and the test, and the center shift unless one sphere contains the other or
// the centers coincide; the last word adds the scale division and the three
// offsets. The result sits in an output register, so the next list may start while it waits to be taken.
module bounding_sphere_merge_normalize (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [30:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  bsmn_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bsmn_pkg::out_word_t out_data
);
  import bsmn_pkg::*;

  cmd_t    cmd;
  status_t st;

  bsmn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bsmn_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/bsmn_checker.sv =====
module bsmn_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input bsmn_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input bsmn_pkg::out_word_t out_data
);
  import bsmn_pkg::*;

  // a held result does not change
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed");

  // an empty list gives the identity transform
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.uniform_scale == IDENTITY_SCALE &&
      out_data.offset_x == 0 && out_data.offset_y == 0 && out_data.offset_z == 0)
    else $error("identity result wrong");

  // an accepted word keeps the input busy for its work
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not busy after accept");

  // a new result only after the word that ends a list
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !in_data.last |=> ##1 !$rose(out_valid))
    else $error("result too early");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bounding_sphere_merge_normalize bsmn_checker u_chk (.*);
